// File: rtl/tsvco_pkg.sv
// ----------------------------------------------------------------------------
// tsvco_pkg
// Shared constants and the cell record type for the TSV cell offset splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tsvco_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 65536;
   localparam int OFFSET_BITS = 24;

   localparam int COL_BITS  = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_BITS  = $clog2(MAX_ROWS + 1);
   localparam int ROW_OUT_BITS   = 16;
   localparam int COL_OUT_BITS   = 8;
   localparam int WIDTH_OUT_BITS = 9;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [ROW_OUT_BITS-1:0]   cell_row;
      logic [COL_OUT_BITS-1:0]   cell_column;
      logic [OFFSET_BITS-1:0]    cell_start;
      logic [OFFSET_BITS-1:0]    cell_length;
      logic                      row_done;
      logic [WIDTH_OUT_BITS-1:0] table_width;
      logic                      overflow_seen;
      logic                      final_cell;
   } cell_rec_type;

endpackage

`default_nettype wire

// File: rtl/tsv_cell_offset_splitter.sv
// ----------------------------------------------------------------------------
// tsv_cell_offset_splitter
// Splits a tab-separated byte stream into cell records (row, column, start
// offset, length, row end, table width, overflow, final cell).
//
// Input side is a queue write port: a beat is taken when push is high and
// full is low. One byte per beat, end_of_file on the last byte of a file.
// Result side is a queue read port: the oldest record sits on the rsp_ ports
// while empty is low and leaves when pop is high.
// Throughput is one byte per clock while full is low; the parser updates all
// state in the cycle a byte is taken. A record shows in the queue in the cycle
// after the byte that ends its cell. Bytes that end no cell produce nothing.
// A four-entry record queue sits between parser and result port. When the
// receiver stops popping, bytes keep flowing until the queue fills, then full
// rises and holds off the sender.
// Synchronous reset clears the parser state and empties the queue. The
// end_of_file byte also returns the parser to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_cell_offset_splitter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   req_text_byte,
   input  wire logic         req_end_of_file,
   output logic              empty,
   input  wire logic         pop,
   output logic [15:0]       rsp_cell_row,
   output logic [7:0]        rsp_cell_column,
   output logic [23:0]       rsp_cell_start,
   output logic [23:0]       rsp_cell_length,
   output logic              rsp_row_done,
   output logic [8:0]        rsp_table_width,
   output logic              rsp_overflow_seen,
   output logic              rsp_final_cell
);
   import tsvco_pkg::*;

   logic         beat_valid;
   logic         rec_valid;
   cell_rec_type rec;
   cell_rec_type head;

   assign beat_valid = push && !full;

   tsvco_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (beat_valid),
      .text_byte   (req_text_byte),
      .end_of_file (req_end_of_file),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   tsvco_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_valid),
      .wr_data (rec),
      .full    (full),
      .rd_en   (pop),
      .empty   (empty),
      .rd_data (head)
   );

   assign rsp_cell_row      = head.cell_row;
   assign rsp_cell_column   = head.cell_column;
   assign rsp_cell_start    = head.cell_start;
   assign rsp_cell_length   = head.cell_length;
   assign rsp_row_done      = head.row_done;
   assign rsp_table_width   = head.table_width;
   assign rsp_overflow_seen = head.overflow_seen;
   assign rsp_final_cell    = head.final_cell;

endmodule

`default_nettype wire

// File: rtl/tsvco_front.sv
// ----------------------------------------------------------------------------
// tsvco_front
// Byte classifier and parse state: tracks offsets, row and column, and builds
// one cell record per cell ending inside the table width and row limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvco_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    beat_valid,
   input  wire logic [7:0]              text_byte,
   input  wire logic                    end_of_file,
   output logic                         rec_valid,
   output tsvco_pkg::cell_rec_type      rec
);
   import tsvco_pkg::*;

   logic [OFFSET_BITS-1:0] pos_ff,   pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [COL_BITS-1:0]    col_ff,   col_in;
   logic [ROW_BITS-1:0]    row_ff,   row_in;
   logic [COL_BITS-1:0]    kw_ff,    kw_in;
   logic                   wf_ff,    wf_in;
   logic                   acr_ff,   acr_in;
   logic                   ovf_ff,   ovf_in;

   logic                   is_tab, is_eol, swallow, ordinary, ends_cell, keep;
   logic [OFFSET_BITS-1:0] pos_inc, len;
   logic [COL_BITS-1:0]    limit, kw_new;
   logic [COL_BITS:0]      col_plus;

   always_comb begin
      is_tab   = (text_byte == CH_TAB);
      is_eol   = (text_byte == CH_CR) || (text_byte == CH_LF);
      swallow  = acr_ff && (text_byte == CH_LF);
      ordinary = !is_tab && !is_eol;
      ends_cell = !swallow && (!ordinary || end_of_file);
      pos_inc  = (pos_ff == OFFSET_MAX) ? OFFSET_MAX : pos_ff + 1'b1;

      len = (pos_ff >= start_ff) ? pos_ff - start_ff : '0;
      if (ordinary && (len != OFFSET_MAX)) begin
         len = len + 1'b1;
      end

      limit    = wf_ff ? kw_ff : COL_BITS'(MAX_COLUMNS);
      col_plus = {1'b0, col_ff} + 1'b1;
      kw_new   = (col_plus > (COL_BITS+1)'(MAX_COLUMNS)) ? COL_BITS'(MAX_COLUMNS)
                                                          : col_plus[COL_BITS-1:0];
      keep = (col_ff < limit) && (row_ff < ROW_BITS'(MAX_ROWS));

      pos_in   = pos_ff;
      start_in = start_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      kw_in    = kw_ff;
      wf_in    = wf_ff;
      acr_in   = acr_ff;
      ovf_in   = ovf_ff;

      if (beat_valid) begin
         pos_in = pos_inc;
         acr_in = 1'b0;
         if (swallow) begin
            start_in = pos_inc;
         end else if (ends_cell) begin
            start_in = pos_inc;
            if (!wf_ff && (is_eol || end_of_file)) begin
               kw_in = kw_new;
               wf_in = 1'b1;
            end
            if (!keep) begin
               ovf_in = 1'b1;
            end
            if (is_tab) begin
               if (col_ff < COL_BITS'(MAX_COLUMNS)) begin
                  col_in = col_ff + 1'b1;
               end
            end else if (is_eol) begin
               col_in = '0;
               if (row_ff < ROW_BITS'(MAX_ROWS)) begin
                  row_in = row_ff + 1'b1;
               end
               acr_in = (text_byte == CH_CR);
            end
         end
         if (end_of_file) begin
            pos_in   = '0;
            start_in = '0;
            col_in   = '0;
            row_in   = '0;
            kw_in    = '0;
            wf_in    = 1'b0;
            acr_in   = 1'b0;
            ovf_in   = 1'b0;
         end
      end

      rec_valid = beat_valid && ends_cell && keep;
      rec.cell_row = (row_ff > ROW_BITS'(16'hFFFF)) ? 16'hFFFF : row_ff[ROW_OUT_BITS-1:0];
      rec.cell_column = col_ff[COL_OUT_BITS-1:0];
      rec.cell_start  = start_ff;
      rec.cell_length = len;
      rec.row_done    = is_eol;
      rec.table_width = (wf_ff || is_eol || end_of_file)
                        ? ((wf_ff ? kw_ff : kw_new)) : '0;
      rec.overflow_seen = ovf_ff;
      rec.final_cell    = end_of_file;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         kw_ff    <= '0;
         wf_ff    <= 1'b0;
         acr_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         kw_ff    <= kw_in;
         wf_ff    <= wf_in;
         acr_ff   <= acr_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tsvco_fifo.sv
// ----------------------------------------------------------------------------
// tsvco_fifo
// Short record queue between the parser and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvco_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  tsvco_pkg::cell_rec_type      wr_data,
   output logic                         full,
   input  wire logic                    rd_en,
   output logic                         empty,
   output tsvco_pkg::cell_rec_type      rd_data
);
   import tsvco_pkg::*;

   cell_rec_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]   cnt_ff,    cnt_in;
   logic                       do_wr, do_rd;

   always_comb begin
      full    = (cnt_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
      empty   = (cnt_ff == '0);
      do_wr   = wr_en && !full;
      do_rd   = rd_en && !empty;
      rd_data = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: dv/tsv_cell_offset_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsv_cell_offset_splitter_tb
// Self-checking bench for the TSV cell offset splitter. A short table of
// directed bytes covers byte extremes, every separator, swallowed LF, short
// and long rows and each way a file can end. It is followed by random files,
// mostly well-formed tables with random content and some noise. A very wide
// first line exercises column saturation. Every byte beat runs through a
// local parser model, and each record beat is compared field by field with
// the oldest predicted cell. Sender bursts, receiver stalls and one long
// receiver hold-off are applied throughout.
// ----------------------------------------------------------------------------

module tsv_cell_offset_splitter_tb;

   import tsvco_pkg::*;

   localparam int RANDOM_BYTES    = 1250;
   localparam int IDLE_LIMIT      = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_START      = 300;
   localparam int HOLD_CYCLES     = 120;
   localparam int WIDE_CELLS      = MAX_COLUMNS + 4;
   localparam int MAX_PRINTED     = 40;

   localparam cell_rec_type NO_CELL = '0;

   typedef struct {
      logic [7:0]   text;
      logic         eof;
      bit           pinned;
      cell_rec_type exp_rec;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic [7:0]              req_text_byte = '0;
   logic                    req_end_of_file = 1'b0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic [15:0]             rsp_cell_row;
   logic [7:0]              rsp_cell_column;
   logic [23:0]             rsp_cell_start;
   logic [23:0]             rsp_cell_length;
   logic                    rsp_row_done;
   logic [8:0]              rsp_table_width;
   logic                    rsp_overflow_seen;
   logic                    rsp_final_cell;

   // record pinned to the current beat by the directed table
   bit                      pin_valid = 1'b0;
   cell_rec_type            pin_cell = '0;

   cell_rec_type            expected_cells[$];
   dir_row_type             dir_table[$];
   logic [7:0]              file_buf[$];
   int                      fail_count = 0;
   int                      idle_cycles = 0;
   int                      burst_left = 0;

   // parser model state
   logic [OFFSET_BITS-1:0]  parse_pos;
   logic [OFFSET_BITS-1:0]  cell_begin;
   logic [COL_BITS-1:0]     col_count;
   logic [ROW_BITS-1:0]     row_count;
   logic [COL_BITS-1:0]     width_count;
   bit                      width_known;
   bit                      cr_pending;
   bit                      overflow_hit;

   tsv_cell_offset_splitter dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_text_byte     (req_text_byte),
      .req_end_of_file   (req_end_of_file),
      .empty             (empty),
      .pop               (pop),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_cell_column   (rsp_cell_column),
      .rsp_cell_start    (rsp_cell_start),
      .rsp_cell_length   (rsp_cell_length),
      .rsp_row_done      (rsp_row_done),
      .rsp_table_width   (rsp_table_width),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_final_cell    (rsp_final_cell)
   );

   always #1 clock = ~clock;

   function automatic void clear_parser();
      parse_pos    = '0;
      cell_begin   = '0;
      col_count    = '0;
      row_count    = '0;
      width_count  = '0;
      width_known  = 1'b0;
      cr_pending   = 1'b0;
      overflow_hit = 1'b0;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] offset_step(input logic [OFFSET_BITS-1:0] v);
      return (v == OFFSET_MAX) ? v : v + 1'b1;
   endfunction

   // Advances the parser model by one byte; returns 1 when a cell record results.
   function automatic bit predict_cell(input logic [7:0] b, input logic eof,
                                       output cell_rec_type rec_out);
      logic [OFFSET_BITS-1:0] p;
      logic [OFFSET_BITS-1:0] len;
      logic [COL_BITS-1:0]    limit;
      bit                     is_tab;
      bit                     is_eol;
      bit                     keep;
      p = parse_pos;
      rec_out = '0;
      if (cr_pending && b == CH_LF) begin
         cr_pending = 1'b0;
         cell_begin = offset_step(p);
         parse_pos = offset_step(p);
         if (eof)
            clear_parser();
         return 1'b0;
      end
      cr_pending = 1'b0;
      is_tab = (b == CH_TAB);
      is_eol = (b == CH_CR || b == CH_LF);
      if (!is_tab && !is_eol && !eof) begin
         parse_pos = offset_step(p);
         return 1'b0;
      end
      len = (p >= cell_begin) ? p - cell_begin : '0;
      if (!is_tab && !is_eol && len != OFFSET_MAX)
         len = len + 1'b1;
      limit = width_known ? width_count : COL_BITS'(MAX_COLUMNS);
      if (!width_known && (is_eol || eof)) begin
         width_count = (col_count >= COL_BITS'(MAX_COLUMNS)) ? COL_BITS'(MAX_COLUMNS)
                                                             : col_count + 1'b1;
         width_known = 1'b1;
      end
      keep = (col_count < limit) && (row_count < ROW_BITS'(MAX_ROWS));
      if (!keep)
         overflow_hit = 1'b1;
      if (keep) begin
         rec_out.cell_row      = (row_count > ROW_BITS'(16'hFFFF)) ? 16'hFFFF
                                                                  : row_count[15:0];
         rec_out.cell_column   = col_count[7:0];
         rec_out.cell_start    = cell_begin;
         rec_out.cell_length   = len;
         rec_out.row_done      = is_eol;
         rec_out.table_width   = width_known ? width_count : '0;
         rec_out.overflow_seen = overflow_hit;
         rec_out.final_cell    = eof;
      end
      if (is_tab) begin
         if (col_count < COL_BITS'(MAX_COLUMNS))
            col_count = col_count + 1'b1;
      end else if (is_eol) begin
         col_count = '0;
         if (row_count < ROW_BITS'(MAX_ROWS))
            row_count = row_count + 1'b1;
         cr_pending = (b == CH_CR);
      end
      cell_begin = offset_step(p);
      parse_pos = offset_step(p);
      if (eof)
         clear_parser();
      return keep;
   endfunction

   function automatic cell_rec_type mk_cell(input int unsigned row, col, start, len,
                                            input bit rd, input int unsigned tw,
                                            input bit ovf, input bit fin);
      cell_rec_type c;
      c.cell_row      = row[15:0];
      c.cell_column   = col[7:0];
      c.cell_start    = start[23:0];
      c.cell_length   = len[23:0];
      c.row_done      = rd;
      c.table_width   = tw[8:0];
      c.overflow_seen = ovf;
      c.final_cell    = fin;
      return c;
   endfunction

   function automatic void tab_row(input logic [7:0] t, input logic e, input bit pin,
                                   input cell_rec_type c);
      dir_row_type r;
      r.text = t;
      r.eof = e;
      r.pinned = pin;
      r.exp_rec = c;
      dir_table.push_back(r);
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == CH_TAB || c == CH_CR || c == CH_LF);
      return c;
   endfunction

   // Well-formed table: first line sets the width, later rows run short or long.
   function automatic void build_table();
      int ncols;
      int nrows;
      int cells;
      int clen;
      int kind;
      file_buf.delete();
      ncols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
      nrows = $urandom_range(1, 6);
      clen = 0;
      for (int r = 0; r < nrows; r++) begin
         cells = (r == 0) ? ncols : ncols - 1 + $urandom_range(0, 3);
         if (cells < 1)
            cells = 1;
         for (int c = 0; c < cells; c++) begin
            clen = $urandom_range(0, 4);
            for (int k = 0; k < clen; k++)
               file_buf.push_back(text_char());
            if (c != cells - 1)
               file_buf.push_back(CH_TAB);
         end
         kind = (r == nrows - 1) ? $urandom_range(0, 4) : $urandom_range(0, 2);
         case (kind)
            0: file_buf.push_back(CH_LF);
            1: file_buf.push_back(CH_CR);
            2: begin
               file_buf.push_back(CH_CR);
               file_buf.push_back(CH_LF);
            end
            3: file_buf.push_back(CH_TAB);
            default: begin
               if (clen == 0)
                  file_buf.push_back(text_char());
            end
         endcase
      end
   endfunction

   function automatic void build_noise();
      int n;
      n = $urandom_range(1, 30);
      file_buf.delete();
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: file_buf.push_back(CH_TAB);
            1: file_buf.push_back(CH_CR);
            2: file_buf.push_back(CH_LF);
            default: file_buf.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_PRINTED)
         $display("ERROR %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [7:0] b, input logic e, input bit pin,
                            input cell_rec_type c);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap = 0;
            burst_left = $urandom_range(100, 300);
         end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            push <= 1'b0;
            pin_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_text_byte <= b;
      req_end_of_file <= e;
      pin_valid <= pin;
      pin_cell <= c;
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_buf.size(); i++)
         send_beat(file_buf[i], i == file_buf.size() - 1, 1'b0, NO_CELL);
   endtask

   always @(posedge clock) begin : cell_check
      cell_rec_type pred;
      cell_rec_type got;
      cell_rec_type want;
      bit           has_cell;
      if (reset) begin
         clear_parser();
         idle_cycles = 0;
      end else begin
         if (push && !full) begin
            has_cell = predict_cell(req_text_byte, req_end_of_file, pred);
            if (pin_valid) begin
               has_cell = 1'b1;
               pred = pin_cell;
            end
            if (has_cell)
               expected_cells.push_back(pred);
         end
         if (pop && !empty) begin
            got.cell_row      = rsp_cell_row;
            got.cell_column   = rsp_cell_column;
            got.cell_start    = rsp_cell_start;
            got.cell_length   = rsp_cell_length;
            got.row_done      = rsp_row_done;
            got.table_width   = rsp_table_width;
            got.overflow_seen = rsp_overflow_seen;
            got.final_cell    = rsp_final_cell;
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("unexpected record row %0d col %0d start %0d",
                                         got.cell_row, got.cell_column, got.cell_start));
            end else begin
               want = expected_cells.pop_front();
               check_field("cell_row", got.cell_row, want.cell_row);
               check_field("cell_column", got.cell_column, want.cell_column);
               check_field("cell_start", got.cell_start, want.cell_start);
               check_field("cell_length", got.cell_length, want.cell_length);
               check_field("row_done", got.row_done, want.row_done);
               check_field("table_width", got.table_width, want.table_width);
               check_field("overflow_seen", got.overflow_seen, want.overflow_seen);
               check_field("final_cell", got.final_cell, want.final_cell);
            end
         end
         if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("tsv_cell_offset_splitter regression: fail");
               $finish;
            end
         end
      end
   end

   // receiver: stall mode is re-picked at random, plus one long hold-off
   initial begin : receiver
      int cyc;
      int mode;
      int hold_left;
      cyc = 0;
      mode = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (!reset)
            cyc++;
         if (cyc == HOLD_START)
            hold_left = HOLD_CYCLES;
         if (cyc % 64 == 0)
            mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case (mode)
               0: pop <= 1'b1;
               1: pop <= ($urandom_range(0, 3) != 0);
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int sent;
      // file 1: extremes, short and long rows, CRLF, lone CRs, eof on a text byte
      tab_row(8'h61, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_TAB, 1'b0, 1'b1, mk_cell(0, 0, 0, 1, 1'b0, 0, 1'b0, 1'b0));
      tab_row(8'h00, 1'b0, 1'b0, NO_CELL);
      tab_row(8'hFF, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_CR, 1'b0, 1'b1, mk_cell(0, 1, 2, 2, 1'b1, 2, 1'b0, 1'b0));
      tab_row(CH_LF, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_TAB, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_TAB, 1'b0, 1'b0, NO_CELL);
      tab_row(8'h78, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_TAB, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_LF, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_LF, 1'b0, 1'b1, mk_cell(2, 0, 11, 0, 1'b1, 2, 1'b1, 1'b0));
      tab_row(CH_CR, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_CR, 1'b0, 1'b0, NO_CELL);
      tab_row(8'h7A, 1'b1, 1'b1, mk_cell(5, 0, 14, 1, 1'b0, 2, 1'b1, 1'b1));
      // one-byte files: first line without line end, eof on tab
      tab_row(8'h71, 1'b1, 1'b1, mk_cell(0, 0, 0, 1, 1'b0, 1, 1'b0, 1'b1));
      tab_row(CH_TAB, 1'b1, 1'b1, mk_cell(0, 0, 0, 0, 1'b0, 1, 1'b0, 1'b1));
      // eof on a swallowed LF, then a one-byte file with eof on LF, then eof on CR
      tab_row(CH_CR, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_LF, 1'b1, 1'b0, NO_CELL);
      tab_row(CH_LF, 1'b1, 1'b1, mk_cell(0, 0, 0, 0, 1'b1, 1, 1'b0, 1'b1));
      tab_row(CH_TAB, 1'b0, 1'b0, NO_CELL);
      tab_row(CH_CR, 1'b1, 1'b1, mk_cell(0, 1, 1, 0, 1'b1, 2, 1'b0, 1'b1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_beat(dir_table[i].text, dir_table[i].eof, dir_table[i].pinned,
                   dir_table[i].exp_rec);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 4) == 0)
            build_noise();
         else
            build_table();
         send_file();
         sent += file_buf.size();
      end

      // first line wider than the column limit, then a short second row
      file_buf.delete();
      for (int i = 0; i < WIDE_CELLS; i++) begin
         file_buf.push_back(text_char());
         file_buf.push_back((i == WIDE_CELLS - 1) ? CH_LF : CH_TAB);
      end
      for (int i = 0; i < 3; i++) begin
         file_buf.push_back(text_char());
         file_buf.push_back((i == 2) ? CH_LF : CH_TAB);
      end
      send_file();

      push <= 1'b0;
      pin_valid <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tsv_cell_offset_splitter regression: pass");
      else
         $display("tsv_cell_offset_splitter regression: fail");
      $finish;
   end

endmodule
